/* hdl/scbr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package scbr_pkg;

  // Fixed field widths
  localparam int BUTTON_BITS = 5;
  localparam int HOUR_BITS   = 5;
  localparam int MINSEC_BITS = 6;
  localparam int TPS_BITS    = 10;
  localparam int LOCK_BITS   = 8;
  localparam int RPT_BITS    = 8;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 10;

  // Time limits
  localparam logic [HOUR_BITS-1:0]   HOUR_MAX   = 5'd23;
  localparam logic [MINSEC_BITS-1:0] MINSEC_MAX = 6'd59;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_TICKS_PER_SECOND = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LOCKOUT_TICKS    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_REPEAT_TICKS     = 2'd2;

  // Configuration reset values
  localparam logic [TPS_BITS-1:0]  TPS_RESET  = 10'd100;
  localparam logic [LOCK_BITS-1:0] LOCK_RESET = 8'd20;
  localparam logic [RPT_BITS-1:0]  RPT_RESET  = 8'd50;

  // Item kinds
  localparam logic MODE_TICK   = 1'b0;
  localparam logic MODE_BUTTON = 1'b1;

  // Button codes
  localparam logic [BUTTON_BITS-1:0] BTN_NONE     = 5'h00;
  localparam logic [BUTTON_BITS-1:0] BTN_HOUR_UP  = 5'h18;
  localparam logic [BUTTON_BITS-1:0] BTN_HOUR_DN  = 5'h0c;
  localparam logic [BUTTON_BITS-1:0] BTN_MIN_UP   = 5'h11;
  localparam logic [BUTTON_BITS-1:0] BTN_MIN_DN   = 5'h05;
  localparam logic [BUTTON_BITS-1:0] BTN_SEC_UP   = 5'h12;
  localparam logic [BUTTON_BITS-1:0] BTN_SEC_DN   = 5'h06;

  typedef struct packed {
    logic                   mode;
    logic [BUTTON_BITS-1:0] buttons;
  } item_t;

  typedef struct packed {
    logic [HOUR_BITS-1:0]   hour_now;
    logic [MINSEC_BITS-1:0] minute_now;
    logic [MINSEC_BITS-1:0] second_now;
    logic                   display_update;
  } result_t;

  typedef struct packed {
    logic [HOUR_BITS-1:0]   hour;
    logic [MINSEC_BITS-1:0] minute;
    logic [MINSEC_BITS-1:0] second;
  } time_t;

  // Adjustment request from the control logic to the time unit
  typedef struct packed {
    logic                   en;
    logic [BUTTON_BITS-1:0] code;
  } adj_t;

endpackage

`default_nettype wire

/* hdl/scbr_time_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

module scbr_time_unit (
  input  wire scbr_pkg::time_t cur,
  input  wire scbr_pkg::adj_t  adj,
  output scbr_pkg::time_t      nxt
);
  import scbr_pkg::*;

  logic [HOUR_BITS-1:0] hour_inc;
  logic [HOUR_BITS-1:0] hour_dec;

  // Hour wrap in both directions
  assign hour_inc = (cur.hour >= HOUR_MAX) ? '0 : cur.hour + 5'd1;
  assign hour_dec = (cur.hour == '0) ? HOUR_MAX : cur.hour - 5'd1;

  // Apply one adjustment code with carry and borrow
  always_comb begin
    nxt = cur;
    if (adj.en) begin
      unique case (adj.code)
        BTN_HOUR_UP: nxt.hour = hour_inc;
        BTN_HOUR_DN: nxt.hour = hour_dec;
        BTN_MIN_UP: begin
          if (cur.minute >= MINSEC_MAX) begin
            nxt.minute = '0;
            nxt.hour   = hour_inc;
          end else begin
            nxt.minute = cur.minute + 6'd1;
          end
        end
        BTN_MIN_DN: begin
          if (cur.minute == '0) begin
            nxt.minute = MINSEC_MAX;
            if (cur.hour != '0) nxt.hour = cur.hour - 5'd1;
          end else begin
            nxt.minute = cur.minute - 6'd1;
          end
        end
        BTN_SEC_UP: begin
          if (cur.second >= MINSEC_MAX) begin
            nxt.second = '0;
            if (cur.minute >= MINSEC_MAX) begin
              nxt.minute = '0;
              nxt.hour   = hour_inc;
            end else begin
              nxt.minute = cur.minute + 6'd1;
            end
          end else begin
            nxt.second = cur.second + 6'd1;
          end
        end
        BTN_SEC_DN: begin
          if (cur.second == '0) begin
            nxt.second = MINSEC_MAX;
            if (cur.minute != '0) nxt.minute = cur.minute - 6'd1;
          end else begin
            nxt.second = cur.second - 6'd1;
          end
        end
        default: nxt = cur;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/scbr_core.sv */
`timescale 1ns / 1ps
`default_nettype none

module scbr_core (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 cfg_we,
  input  wire [scbr_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire [scbr_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  wire                                 step,
  input  wire scbr_pkg::item_t                word,
  output scbr_pkg::result_t                   res
);
  import scbr_pkg::*;

  // Configuration registers
  logic [TPS_BITS-1:0]  ticks_per_second;
  logic [LOCK_BITS-1:0] lockout_ticks;
  logic [RPT_BITS-1:0]  repeat_ticks;

  // Clock state
  logic [TPS_BITS-1:0]    second_ticks, second_ticks_next;
  logic [LOCK_BITS-1:0]   lockout_count, lockout_count_next;
  logic [RPT_BITS-1:0]    repeat_count, repeat_count_next;
  logic                   accept_ready, accept_ready_next;
  logic [BUTTON_BITS-1:0] held_buttons, held_buttons_next;
  logic                   hold_active, hold_active_next;
  time_t                  time_cur, time_next;

  logic [TPS_BITS:0]  st_inc;
  logic [LOCK_BITS:0] lc_inc;
  logic [RPT_BITS-1:0] rc_inc;
  logic               tps_hit;
  logic               lock_hit;
  logic               apply_req;
  logic               tick_adv;
  logic               upd;
  adj_t               adj;

  // Write configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= TPS_RESET;
      lockout_ticks    <= LOCK_RESET;
      repeat_ticks     <= RPT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TICKS_PER_SECOND: ticks_per_second <= cfg_data;
        REG_LOCKOUT_TICKS:    lockout_ticks    <= cfg_data[LOCK_BITS-1:0];
        REG_REPEAT_TICKS:     repeat_ticks     <= cfg_data[RPT_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign st_inc   = {1'b0, second_ticks} + 11'd1;
  assign lc_inc   = {1'b0, lockout_count} + 9'd1;
  assign rc_inc   = (repeat_count == '1) ? repeat_count : repeat_count + 8'd1;
  assign tps_hit  = st_inc >= {1'b0, ticks_per_second};
  assign lock_hit = lc_inc >= {1'b0, lockout_ticks};

  // Work out the next state for one word
  always_comb begin
    second_ticks_next  = second_ticks;
    lockout_count_next = lockout_count;
    repeat_count_next  = repeat_count;
    accept_ready_next  = accept_ready;
    held_buttons_next  = held_buttons;
    hold_active_next   = hold_active;
    apply_req          = 1'b0;
    tick_adv           = 1'b0;
    upd                = 1'b0;
    adj.en             = 1'b0;
    adj.code           = held_buttons;

    if (word.mode == MODE_TICK) begin
      second_ticks_next  = st_inc[TPS_BITS-1:0];
      lockout_count_next = lc_inc[LOCK_BITS-1:0];
      repeat_count_next  = rc_inc;
      if (held_buttons == BTN_NONE) begin
        hold_active_next = 1'b0;
        if (tps_hit) begin
          second_ticks_next = '0;
          tick_adv          = 1'b1;
          upd               = 1'b1;
        end
      end else if (tps_hit) begin
        second_ticks_next = '0;
        hold_active_next  = 1'b1;
        repeat_count_next = '0;
      end
      // Auto-repeat the held code
      if (hold_active_next && (repeat_count_next >= repeat_ticks)) begin
        repeat_count_next = '0;
        apply_req         = 1'b1;
      end
    end else begin
      held_buttons_next = word.buttons;
      adj.code          = word.buttons;
      apply_req         = 1'b1;
    end

    // Accept the code only when armed
    if (apply_req && accept_ready) begin
      second_ticks_next = '0;
      accept_ready_next = 1'b0;
      upd               = 1'b1;
      adj.en            = 1'b1;
    end

    // Rearm after the lockout window
    if ((word.mode == MODE_TICK) && lock_hit) begin
      lockout_count_next = '0;
      accept_ready_next  = 1'b1;
    end

    // Plain second advance shares the time unit
    if (tick_adv) begin
      adj.en   = 1'b1;
      adj.code = BTN_SEC_UP;
    end
  end

  scbr_time_unit u_time (
    .cur (time_cur),
    .adj (adj),
    .nxt (time_next)
  );

  // Advance state on each processed word
  always_ff @(posedge clk) begin
    if (rst) begin
      second_ticks  <= '0;
      lockout_count <= '0;
      repeat_count  <= '0;
      accept_ready  <= 1'b0;
      held_buttons  <= '0;
      hold_active   <= 1'b0;
      time_cur      <= '0;
    end else if (step) begin
      second_ticks  <= second_ticks_next;
      lockout_count <= lockout_count_next;
      repeat_count  <= repeat_count_next;
      accept_ready  <= accept_ready_next;
      held_buttons  <= held_buttons_next;
      hold_active   <= hold_active_next;
      time_cur      <= time_next;
    end
  end

  assign res = {time_next.hour, time_next.minute, time_next.second, upd};

endmodule

`default_nettype wire

/* hdl/settable_clock_with_button_repeat.sv */
`timescale 1ns / 1ps
`default_nettype none

// 24-hour clock set by push buttons. Each input word is either a timer tick or
// a new button state, and each gives exactly one result word with the time
// after it and a display_update flag. A word passes an input register, then
// the counter and time logic, then the result register. One word is taken
// every cycle, limited only by result_stall.
// The input register can take one more word while a result waits, then stalls.
// Configuration (ticks_per_second, lockout_ticks, repeat_ticks) takes effect on
// the next word and is meant to be written only while no word is in flight.
module settable_clock_with_button_repeat (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               item_valid,
  output logic                              item_stall,
  input  wire scbr_pkg::item_t              item,
  output logic                              result_valid,
  input  wire                               result_stall,
  output scbr_pkg::result_t                 result,
  input  wire                               cfg_we,
  input  wire [scbr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire [scbr_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import scbr_pkg::*;

  logic    s0_valid;
  item_t   s0_word;
  logic    s0_advance;
  result_t res_next;

  // Move the held word on when the result register is free
  assign s0_advance = s0_valid && (!result_valid || !result_stall);
  assign item_stall = s0_valid && !s0_advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (!item_stall) begin
      s0_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) s0_word <= item;
  end

  scbr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (s0_advance),
    .word      (s0_word),
    .res       (res_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s0_advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_advance) result <= res_next;
  end

endmodule

`default_nettype wire

/* hdl/scbr_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module scbr_checker (
  input wire                    clk,
  input wire                    rst,
  input wire                    item_stall,
  input wire                    result_valid,
  input wire                    result_stall,
  input wire scbr_pkg::result_t result
);
  import scbr_pkg::*;

  time_t last_time;

  // Track the time of the last delivered word
  always_ff @(posedge clk) begin
    if (rst) begin
      last_time <= '0;
    end else if (result_valid && !result_stall) begin
      last_time <= {result.hour_now, result.minute_now, result.second_now};
    end
  end

  a_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.hour_now <= HOUR_MAX) && (result.minute_now <= MINSEC_MAX)
                     && (result.second_now <= MINSEC_MAX))
    else $error("time field out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result word changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (result_valid && result_stall))
    else $error("input stalled while result side free");

  a_no_update: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.display_update) |->
      (result.hour_now == last_time.hour) && (result.minute_now == last_time.minute)
      && (result.second_now == last_time.second))
    else $error("time changed without display update");

endmodule

bind settable_clock_with_button_repeat scbr_checker u_scbr_checker (
  .clk          (clk),
  .rst          (rst),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire

/* dv/tb_settable_clock_with_button_repeat.sv */
`timescale 1ns / 1ps

module tb_settable_clock_with_button_repeat;
  import scbr_pkg::*;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int HOLDOFF_CYCLES = 60;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;
  localparam logic [RPT_BITS-1:0]     RPT_SAT   = 8'hff;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic     item_valid = 1'b0;
  logic     item_stall;
  item_t    in_word = '0;
  logic     result_valid;
  logic     result_stall = 1'b0;
  result_t  out_word;
  logic     cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // Words waiting to be offered, and clock readings still owed by the block
  item_t   pending_words[$];
  result_t expected_times[$];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  bit holdoff_wanted = 1'b0;
  int fail_count    = 0;
  int cycle_count   = 0;

  logic [BUTTON_BITS-1:0] press_codes [6] = '{BTN_HOUR_UP, BTN_HOUR_DN, BTN_MIN_UP,
                                              BTN_MIN_DN, BTN_SEC_UP, BTN_SEC_DN};

  // Clock model state and its copy of the registers
  logic [TPS_BITS-1:0]    tps_cfg;
  logic [LOCK_BITS-1:0]   lock_cfg;
  logic [RPT_BITS-1:0]    rpt_cfg;
  logic [TPS_BITS-1:0]    sec_ticks;
  logic [LOCK_BITS-1:0]   lock_cnt;
  logic [RPT_BITS-1:0]    rpt_cnt;
  logic                   armed;
  logic [BUTTON_BITS-1:0] held;
  logic                   holding;
  logic [HOUR_BITS-1:0]   hh;
  logic [MINSEC_BITS-1:0] mm;
  logic [MINSEC_BITS-1:0] ss;

  settable_clock_with_button_repeat u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (in_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (out_word),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic void hour_up();
    hh = (hh >= HOUR_MAX) ? '0 : hh + 1'b1;
  endfunction

  function automatic void minute_up();
    if (mm >= MINSEC_MAX) begin
      mm = '0;
      hour_up();
    end else begin
      mm = mm + 1'b1;
    end
  endfunction

  function automatic void second_up();
    if (ss >= MINSEC_MAX) begin
      ss = '0;
      minute_up();
    end else begin
      ss = ss + 1'b1;
    end
  endfunction

  // Apply the held code if acceptance is armed; return 1 when taken
  function automatic logic apply_press();
    if (!armed) return 1'b0;
    sec_ticks = '0;
    armed = 1'b0;
    case (held)
      BTN_HOUR_UP: hour_up();
      BTN_HOUR_DN: hh = (hh == 0) ? HOUR_MAX : hh - 1'b1;
      BTN_MIN_UP: minute_up();
      BTN_MIN_DN: begin
        if (mm == 0) begin
          mm = MINSEC_MAX;
          if (hh != 0) hh = hh - 1'b1;
        end else begin
          mm = mm - 1'b1;
        end
      end
      BTN_SEC_UP: second_up();
      BTN_SEC_DN: begin
        if (ss == 0) begin
          ss = MINSEC_MAX;
          if (mm != 0) mm = mm - 1'b1;
        end else begin
          ss = ss - 1'b1;
        end
      end
      default: ;
    endcase
    return 1'b1;
  endfunction

  // Advance the clock model by one word and return the reading it gives
  function automatic result_t predict_time(item_t w);
    result_t r;
    logic    upd;
    upd = 1'b0;
    if (w.mode == MODE_TICK) begin
      sec_ticks = sec_ticks + 1'b1;
      lock_cnt  = lock_cnt + 1'b1;
      if (rpt_cnt != RPT_SAT) rpt_cnt = rpt_cnt + 1'b1;
      if (held == BTN_NONE) begin
        holding = 1'b0;
        if (sec_ticks >= tps_cfg) begin
          sec_ticks = '0;
          second_up();
          upd = 1'b1;
        end
      end else if (sec_ticks >= tps_cfg) begin
        sec_ticks = '0;
        holding = 1'b1;
        rpt_cnt = '0;
      end
      if (holding && rpt_cnt >= rpt_cfg) begin
        rpt_cnt = '0;
        upd = upd | apply_press();
      end
      if (lock_cnt >= lock_cfg) begin
        lock_cnt = '0;
        armed = 1'b1;
      end
    end else begin
      held = w.buttons;
      upd = apply_press();
    end
    r.hour_now       = hh;
    r.minute_now     = mm;
    r.second_now     = ss;
    r.display_update = upd;
    return r;
  endfunction

  // Driver: hold a stalled word, otherwise offer the next one or idle
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) expected_times.push_back(predict_time(in_word));
      if (!item_valid || !item_stall) begin
        if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_word    <= pending_words.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: one long hold-off when asked, random stalls otherwise
  int  holdoff_left = 0;
  bit  holdoff_done = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      holdoff_left <= 0;
      holdoff_done <= 1'b0;
    end else if (holdoff_left != 0) begin
      result_stall <= 1'b1;
      holdoff_left <= holdoff_left - 1;
    end else if (holdoff_wanted && !holdoff_done && item_valid) begin
      result_stall <= 1'b1;
      holdoff_left <= HOLDOFF_CYCLES;
      holdoff_done <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Monitor: compare each taken word with the oldest expectation
  result_t want;
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_times.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %p", $time, out_word);
        fail_count++;
      end else begin
        want = expected_times.pop_front();
        check_field("hour_now", want.hour_now, out_word.hour_now);
        check_field("minute_now", want.minute_now, out_word.minute_now);
        check_field("second_now", want.second_now, out_word.second_now);
        check_field("display_update", want.display_update, out_word.display_update);
      end
    end
  end

  // Run limit, far above the slowest correct run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_settable_clock_with_button_repeat failed");
      $finish;
    end
  end

  task automatic push_tick();
    item_t w;
    w.mode    = MODE_TICK;
    w.buttons = BUTTON_BITS'($urandom_range(0, 31));
    pending_words.push_back(w);
  endtask

  task automatic push_button(logic [BUTTON_BITS-1:0] b);
    item_t w;
    w.mode    = MODE_BUTTON;
    w.buttons = b;
    pending_words.push_back(w);
  endtask

  // Wait until every word is taken and answered, then let the pipe settle
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_words.size() != 0 || item_valid || expected_times.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_TICKS_PER_SECOND: tps_cfg = val[TPS_BITS-1:0];
      REG_LOCKOUT_TICKS: lock_cfg = val[LOCK_BITS-1:0];
      REG_REPEAT_TICKS: rpt_cfg = val[RPT_BITS-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(int tps, int lock, int rpt);
    write_reg(REG_TICKS_PER_SECOND, CFG_DATA_BITS'(tps));
    write_reg(REG_LOCKOUT_TICKS, CFG_DATA_BITS'(lock));
    write_reg(REG_REPEAT_TICKS, CFG_DATA_BITS'(rpt));
  endtask

  // Mostly press, hold, release sequences; the rest tick bursts and noise
  task automatic push_random(int n);
    int made;
    int k;
    int j;
    int pick;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        push_button(press_codes[$urandom_range(0, 5)]);
        k = $urandom_range(0, 24);
        repeat (k) push_tick();
        push_button(BTN_NONE);
        j = $urandom_range(0, 6);
        repeat (j) push_tick();
        made += k + j + 2;
      end else if (pick < 85) begin
        k = $urandom_range(1, 8);
        repeat (k) push_tick();
        made += k;
      end else begin
        push_button(BUTTON_BITS'($urandom_range(0, 31)));
        made++;
      end
    end
  endtask

  task automatic run_phase(int n, int idle_p, int stall_p, bit holdoff);
    @(negedge clk);
    send_idle_pct  = idle_p;
    stall_pct      = stall_p;
    holdoff_wanted = holdoff;
    push_random(n);
    wait_idle();
  endtask

  initial begin
    tps_cfg   = TPS_RESET;
    lock_cfg  = LOCK_RESET;
    rpt_cfg   = RPT_RESET;
    sec_ticks = '0;
    lock_cnt  = '0;
    rpt_cnt   = '0;
    armed     = 1'b0;
    held      = BTN_NONE;
    holding   = 1'b0;
    hh        = '0;
    mm        = '0;
    ss        = '0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset values: a press while locked out is only stored
    @(negedge clk);
    push_tick();
    push_button(BTN_HOUR_UP);
    push_tick();
    wait_idle();

    // Directed: borrows at zero, minute and hour wrap on carry, unknown codes
    set_regs(2, 1, 255);
    @(negedge clk);
    push_button(BTN_NONE);
    push_tick();
    push_button(BTN_SEC_DN);
    push_tick();
    push_button(BTN_SEC_DN);
    push_tick();
    push_button(BTN_MIN_DN);
    push_tick();
    push_button(BTN_HOUR_DN);
    push_tick();
    push_button(BTN_SEC_UP);
    push_tick();
    push_button(BTN_MIN_UP);
    push_tick();
    push_button(BTN_HOUR_UP);
    push_tick();
    push_button(5'h1f);
    push_tick();
    push_button(BTN_NONE);
    repeat (3) push_tick();
    wait_idle();

    // Random phases over several register settings
    set_regs(3, 2, 2);
    run_phase(150, 0, 0, 1'b1);
    set_regs(1, 1, 1);
    run_phase(120, 46, 0, 1'b0);
    set_regs(5, 3, 4);
    write_reg(REG_SPARE, 10'h3ff);
    run_phase(120, 0, 46, 1'b0);
    set_regs(1023, 255, 255);
    run_phase(80, 36, 36, 1'b0);
    // Lowered limits act at once on the counters left high
    set_regs(2, 1, 3);
    run_phase(150, 36, 36, 1'b0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && expected_times.size() == 0) begin
      $display("tb_settable_clock_with_button_repeat passed");
    end else begin
      $display("tb_settable_clock_with_button_repeat failed");
    end
    $finish;
  end

endmodule
